FILE: design/sjf_pkg.sv
// Package: shared payload types and constants for the SJF scheduler.
`default_nettype none
package sjf_pkg;
    localparam int TIME_W = 21;
    localparam logic [TIME_W-1:0] TIME_MAX = 21'h1FFFFF;

    typedef struct packed {
        logic [15:0] job_id;
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
        logic        last_job;
    } in_word_t;

    typedef struct packed {
        logic [15:0]       out_job_id;
        logic [15:0]       out_arrival;
        logic [15:0]       out_burst;
        logic [TIME_W-1:0] wait_time;
        logic [TIME_W-1:0] turnaround_time;
        logic [TIME_W-1:0] completion_time;
        logic              last_result;
    } out_word_t;

    // Job record carried around the cell ring.
    typedef struct packed {
        logic        valid;
        logic        done;
        logic [15:0] id;
        logic [15:0] arrival;
        logic [15:0] burst;
    } job_t;

    // Control from the sequencer to every cell.
    typedef struct packed {
        logic load;   // shift in a new job at the head
        logic rotate; // pass records one place around the ring
        logic mark;   // set done on the record leaving the tail
        logic clear;  // drop all records
    } cell_ctrl_t;
endpackage
`default_nettype wire

FILE: design/sjf_cell.sv
// Cell: one stored job record, handed to the next cell on load or rotate.
`default_nettype none
module sjf_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sjf_pkg::cell_ctrl_t ctrl,
    input  wire sjf_pkg::job_t     prev_job,
    output sjf_pkg::job_t          job
);
    sjf_pkg::job_t job_next;
    logic          valid_reg;
    logic          done_reg;
    logic [15:0]   id_reg;
    logic [15:0]   arrival_reg;
    logic [15:0]   burst_reg;

    assign job = {valid_reg, done_reg, id_reg, arrival_reg, burst_reg};

    always_comb
    begin
        job_next = job;
        if (ctrl.clear)
        begin
            job_next.valid = 1'b0;
            job_next.done  = 1'b0;
        end
        else if (ctrl.load || ctrl.rotate)
        begin
            job_next = prev_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= job_next.valid;
            done_reg  <= job_next.done;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg      <= job_next.id;
        arrival_reg <= job_next.arrival;
        burst_reg   <= job_next.burst;
    end
endmodule
`default_nettype wire

FILE: design/sjf_nonpreemptive_scheduler.sv
// Top level: non-preemptive shortest-job-first scheduler on a ring of job cells.
`default_nettype none
// Jobs load one word per cycle into a ring of MAX_JOBS cells; the word with
// last_job set starts a schedule. Each decision rotates the ring through two
// full turns: the first finds the earliest arrival among unfinished jobs,
// the second picks the smallest burst among arrived jobs (ties to earlier
// arrival, then load order). A third turn brings the winner to the tail,
// where it is marked done and its result word is formed. A word beyond
// capacity is dropped, but its last_job bit still schedules. Times
// saturate at 2097151. The block takes no input while scheduling.
module sjf_nonpreemptive_scheduler #(
    parameter int MAX_JOBS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire sjf_pkg::in_word_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output sjf_pkg::out_word_t     out_data
);
    localparam int IW = $clog2(MAX_JOBS + 1);
    localparam int TW = sjf_pkg::TIME_W;

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_EARLY = 5'b00010,
        ST_PICK  = 5'b00100,
        ST_SEEK  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [IW-1:0] count_reg, count_next;     // stored jobs
    logic [IW-1:0] left_reg, left_next;       // results still to give
    logic [IW-1:0] step_reg, step_next;       // rotation position
    logic [IW-1:0] best_reg, best_next;       // best position in this turn
    logic          found_reg, found_next;
    logic [15:0]   key_a_reg, key_a_next;     // earliest arrival / best arrival
    logic [15:0]   key_b_reg, key_b_next;     // best burst
    logic [TW-1:0] time_reg, time_next;
    logic          out_valid_reg, out_valid_next;
    sjf_pkg::out_word_t out_reg, out_next;

    sjf_pkg::cell_ctrl_t ctrl;
    sjf_pkg::job_t       ring [MAX_JOBS];
    sjf_pkg::job_t       head_in;
    sjf_pkg::job_t       tail;
    sjf_pkg::job_t       new_job;

    assign tail = ring[MAX_JOBS-1];

    genvar g;
    generate
        for (g = 0; g < MAX_JOBS; g++)
        begin : g_cell
            sjf_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .prev_job ((g == 0) ? head_in : ring[(g == 0) ? 0 : g-1]),
                .job      (ring[g])
            );
        end
    endgenerate

    logic accept_in;
    logic out_free;
    logic live;
    logic [TW:0] done_sum;
    logic [TW-1:0] done_t;
    logic [TW-1:0] arr_t;

    assign in_stall  = (state_reg != ST_LOAD);
    assign accept_in = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign live      = tail.valid && !tail.done;
    assign arr_t     = {{(TW-16){1'b0}}, tail.arrival};
    assign done_sum  = {1'b0, time_reg} + {{(TW-15){1'b0}}, tail.burst};
    assign done_t    = done_sum[TW] ? sjf_pkg::TIME_MAX : done_sum[TW-1:0];

    always_comb
    begin
        new_job.valid   = 1'b1;
        new_job.done    = 1'b0;
        new_job.id      = in_data.job_id;
        new_job.arrival = in_data.arrival_time;
        new_job.burst   = in_data.burst_time;
        // Loads enter at the head; rotation feeds the tail back round,
        // setting done on the winner as it passes.
        head_in         = tail;
        if (ctrl.mark)
        begin
            head_in.done = 1'b1;
        end
        if (ctrl.load)
        begin
            head_in = new_job;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        step_next      = step_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        key_a_next     = key_a_reg;
        key_b_next     = key_b_reg;
        time_next      = time_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        ctrl           = '0;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept_in)
                begin
                    // Loads fill from the head; the ring is full when count
                    // reaches capacity, and oldest jobs sit nearest the tail.
                    if (count_reg < IW'(MAX_JOBS))
                    begin
                        ctrl.load  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (in_data.last_job)
                    begin
                        time_next  = '0;
                        left_next  = (count_reg < IW'(MAX_JOBS))
                                     ? count_reg + 1'b1 : count_reg;
                        step_next  = '0;
                        found_next = 1'b0;
                        state_next = ST_EARLY;
                    end
                end
            end

            ST_EARLY:
            begin
                // Find earliest unfinished arrival over one full turn.
                ctrl.rotate = 1'b1;
                if (live && (!found_reg || tail.arrival < key_a_reg))
                begin
                    key_a_next = tail.arrival;
                    found_next = 1'b1;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == IW'(MAX_JOBS - 1))
                begin
                    // Jump the clock forward when nothing has arrived yet.
                    if (found_next && {{(TW-16){1'b0}}, key_a_next} > time_reg)
                    begin
                        time_next = {{(TW-16){1'b0}}, key_a_next};
                    end
                    step_next  = '0;
                    found_next = 1'b0;
                    state_next = ST_PICK;
                end
            end

            ST_PICK:
            begin
                // Tail order within a turn is load order, so a strict
                // compare keeps the earlier load on a full tie.
                ctrl.rotate = 1'b1;
                if (live && arr_t <= time_reg &&
                    (!found_reg || tail.burst < key_b_reg ||
                     (tail.burst == key_b_reg && tail.arrival < key_a_reg)))
                begin
                    key_a_next = tail.arrival;
                    key_b_next = tail.burst;
                    best_next  = step_reg;
                    found_next = 1'b1;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == IW'(MAX_JOBS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_SEEK;
                end
            end

            ST_SEEK:
            begin
                if (step_reg == best_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    ctrl.rotate = 1'b1;
                    step_next   = step_reg + 1'b1;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    // Winner sits at the tail: emit, mark done, finish the turn.
                    ctrl.rotate = 1'b1;
                    ctrl.mark   = 1'b1;
                    out_valid_next           = 1'b1;
                    out_next.out_job_id      = tail.id;
                    out_next.out_arrival     = tail.arrival;
                    out_next.out_burst       = tail.burst;
                    out_next.wait_time       = time_reg - arr_t;
                    out_next.turnaround_time = done_t - arr_t;
                    out_next.completion_time = done_t;
                    out_next.last_result     = (left_reg == IW'(1));
                    time_next  = done_t;
                    left_next  = left_reg - 1'b1;
                    // Remaining rotation of the turn realigns the ring.
                    step_next  = step_reg + 1'b1;
                    found_next = 1'b0;
                    state_next = ST_SEEK;
                    best_next  = '0;
                    if (step_reg == IW'(MAX_JOBS - 1))
                    begin
                        step_next = '0;
                        state_next = (left_reg == IW'(1)) ? ST_LOAD : ST_EARLY;
                    end
                    if (left_reg == IW'(1))
                    begin
                        count_next = '0;
                        if (step_reg == IW'(MAX_JOBS - 1))
                        begin
                            ctrl.rotate = 1'b0;
                            ctrl.mark   = 1'b0;
                            ctrl.clear  = 1'b1;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // Realign pass after an emit: rotate until a full turn is done.
        if (state_reg == ST_SEEK && best_reg == '0 && step_reg != '0)
        begin
            ctrl.rotate = 1'b1;
            state_next  = ST_SEEK;
            step_next   = step_reg + 1'b1;
            if (step_reg == IW'(MAX_JOBS - 1))
            begin
                step_next = '0;
                if (left_reg == '0)
                begin
                    ctrl.rotate = 1'b0;
                    ctrl.clear  = 1'b1;
                    state_next  = ST_LOAD;
                end
                else
                begin
                    state_next = ST_EARLY;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            left_reg      <= '0;
            step_reg      <= '0;
            best_reg      <= '0;
            found_reg     <= 1'b0;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            step_reg      <= step_next;
            best_reg      <= best_next;
            found_reg     <= found_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_a_reg <= key_a_next;
        key_b_reg <= key_b_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= IW'(MAX_JOBS))
        else $error("job count beyond capacity");
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_LOAD |-> !ctrl.load)
        else $error("load while scheduling");
    a_emit_live: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.mark |-> live)
        else $error("emitted a finished or empty record");
`endif
endmodule
`default_nettype wire
